>>> rtl/oems_pkg.sv
// ----------------------------------------------------------------------------
// oems_pkg: shared definitions for the odd-even merge sort block
// Sizes, index types, sequencer handshake structs and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package oems_pkg;

  localparam int MAX_ELEMENTS = 32;
  localparam int DATA_W       = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  // Schedule counters need headroom for j + 2k past the element count.
  localparam int SEQ_W        = CNT_W + 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [DATA_W-1:0] word_t;

  typedef struct packed {
    logic start;
    logic advance;
  } seq_ctl_t;

  typedef struct packed {
    logic done;
    logic hit;
    idx_t lo;
    idx_t hi;
  } seq_stat_t;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_ISSUE,
    ST_CMP,
    ST_OUT_RD,
    ST_OUT_SHOW
  } state_t;

endpackage

`default_nettype wire

>>> rtl/odd_even_merge_sort_network_core.sv
// ----------------------------------------------------------------------------
// odd_even_merge_sort_network_core: Batcher odd-even merge sorter
// Loads a set of signed values, sorts them in place in memory and streams
// them back in ascending order.
// ----------------------------------------------------------------------------
// Usage:
// The input channel takes one signed 32-bit value per request, one per cycle,
// while the block is loading. The request with in_tlast high ends the set.
// Up to 32 values are kept; later ones are dropped and every result of that
// set carries out_tuser high.
// After the last request of a set of two or more values the block runs the
// comparator schedule against the element memory: for each comparator inside
// the loaded count it reads both entries, then compares and writes back; a
// schedule step that holds no comparator is simply passed over.
// Results then leave one at a time, the final one with out_tlast;
// in_tready stays low from the last input until the last result is taken.
// The memory read port paces both the sort and the output.
// A stalled receiver simply holds the current result on the output port.
// Synchronous reset empties the set; memory contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module odd_even_merge_sort_network_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_tvalid,
  output logic                    in_tready,
  input  wire logic signed [31:0] in_tdata,   // [31:0] value
  input  wire logic               in_tlast,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic signed [31:0]      out_tdata,  // [31:0] sorted_value
  output logic                    out_tlast,
  output logic                    out_tuser   // [0] truncated
);

  localparam int CW = oems_pkg::CNT_W;
  localparam int IW = oems_pkg::IDX_W;

  oems_pkg::state_t    state_r, state_nxt;
  oems_pkg::cnt_t      count_r, count_nxt, count_add, out_idx_r, out_idx_nxt;
  logic                ovf_r, ovf_nxt;
  logic                pend_valid_r, pend_valid_nxt;
  oems_pkg::idx_t      pend_addr_r, pend_addr_nxt;
  oems_pkg::word_t     pend_data_r, pend_data_nxt;
  logic                fwd_a_r, fwd_a_nxt, fwd_b_r, fwd_b_nxt;
  oems_pkg::idx_t      cmp_a_r, cmp_a_nxt, cmp_b_r, cmp_b_nxt;

  logic                we;
  oems_pkg::idx_t      waddr, raddr_a, raddr_b;
  oems_pkg::word_t     wdata, rdata_a, rdata_b, va, vb;
  oems_pkg::seq_ctl_t  seq_ctl;
  oems_pkg::seq_stat_t sched;
  logic                in_acc, full, out_last;

  oems_store u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  oems_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (seq_ctl),
    .count (count_r),
    .stat  (sched)
  );

  assign in_tready  = (state_r == oems_pkg::ST_LOAD);
  assign in_acc     = in_tvalid && in_tready;
  assign full       = (count_r == CW'(oems_pkg::MAX_ELEMENTS));
  assign count_add  = count_r + CW'(!full);
  assign out_last   = (CW'(out_idx_r + CW'(1)) == count_r);
  assign out_tvalid = (state_r == oems_pkg::ST_OUT_SHOW);
  assign out_tdata  = rdata_a;
  assign out_tlast  = out_last;
  assign out_tuser  = ovf_r;

  // The high side of a swap is written in the cycle after the low side; a read issued in that
  // cycle to the same entry takes the held value instead of the memory.
  assign va = fwd_a_r ? pend_data_r : rdata_a;
  assign vb = fwd_b_r ? pend_data_r : rdata_b;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    ovf_nxt        = ovf_r;
    out_idx_nxt    = out_idx_r;
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_data_nxt  = pend_data_r;
    fwd_a_nxt      = fwd_a_r;
    fwd_b_nxt      = fwd_b_r;
    cmp_a_nxt      = cmp_a_r;
    cmp_b_nxt      = cmp_b_r;
    we             = 1'b0;
    waddr          = '0;
    wdata          = '0;
    raddr_a        = sched.lo;
    raddr_b        = sched.hi;
    seq_ctl        = '0;

    unique case (state_r)
      oems_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (!full) begin
            we    = 1'b1;
            waddr = count_r[IW-1:0];
            wdata = in_tdata;
          end
          count_nxt = count_add;
          ovf_nxt   = ovf_r | full;
          if (in_tlast) begin
            out_idx_nxt = '0;
            if (count_add >= CW'(2)) begin
              seq_ctl.start = 1'b1;
              state_nxt     = oems_pkg::ST_ISSUE;
            end else begin
              state_nxt = oems_pkg::ST_OUT_RD;
            end
          end
        end
      end

      oems_pkg::ST_ISSUE: begin
        if (pend_valid_r) begin
          we             = 1'b1;
          waddr          = pend_addr_r;
          wdata          = pend_data_r;
          pend_valid_nxt = 1'b0;
        end
        if (sched.done) begin
          out_idx_nxt = '0;
          state_nxt   = oems_pkg::ST_OUT_RD;
        end else begin
          seq_ctl.advance = 1'b1;
          if (sched.hit) begin
            fwd_a_nxt = pend_valid_r && (pend_addr_r == sched.lo);
            fwd_b_nxt = pend_valid_r && (pend_addr_r == sched.hi);
            cmp_a_nxt = sched.lo;
            cmp_b_nxt = sched.hi;
            state_nxt = oems_pkg::ST_CMP;
          end
        end
      end

      oems_pkg::ST_CMP: begin
        if ($signed(va) > $signed(vb)) begin
          we             = 1'b1;
          waddr          = cmp_a_r;
          wdata          = vb;
          pend_valid_nxt = 1'b1;
          pend_addr_nxt  = cmp_b_r;
          pend_data_nxt  = va;
        end
        state_nxt = oems_pkg::ST_ISSUE;
      end

      oems_pkg::ST_OUT_RD: begin
        raddr_a   = out_idx_r[IW-1:0];
        state_nxt = oems_pkg::ST_OUT_SHOW;
      end

      oems_pkg::ST_OUT_SHOW: begin
        raddr_a = out_idx_r[IW-1:0];
        if (out_tready) begin
          if (out_last) begin
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = oems_pkg::ST_LOAD;
          end else begin
            out_idx_nxt = out_idx_r + CW'(1);
            state_nxt   = oems_pkg::ST_OUT_RD;
          end
        end
      end

      default: begin
        state_nxt = oems_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= oems_pkg::ST_LOAD;
      count_r      <= '0;
      ovf_r        <= 1'b0;
      out_idx_r    <= '0;
      pend_valid_r <= 1'b0;
      fwd_a_r      <= 1'b0;
      fwd_b_r      <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      ovf_r        <= ovf_nxt;
      out_idx_r    <= out_idx_nxt;
      pend_valid_r <= pend_valid_nxt;
      fwd_a_r      <= fwd_a_nxt;
      fwd_b_r      <= fwd_b_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    pend_data_r <= pend_data_nxt;
    cmp_a_r     <= cmp_a_nxt;
    cmp_b_r     <= cmp_b_nxt;
  end

endmodule

`default_nettype wire

>>> rtl/oems_store.sv
// ----------------------------------------------------------------------------
// oems_store: element memory
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module oems_store (
  input  wire logic           clk,
  input  wire logic           we,
  input  wire oems_pkg::idx_t waddr,
  input  wire oems_pkg::word_t wdata,
  input  wire oems_pkg::idx_t raddr_a,
  input  wire oems_pkg::idx_t raddr_b,
  output oems_pkg::word_t     rdata_a,
  output oems_pkg::word_t     rdata_b
);

  oems_pkg::word_t mem [oems_pkg::MAX_ELEMENTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

>>> rtl/oems_seq.sv
// ----------------------------------------------------------------------------
// oems_seq: comparator schedule generator
// Walks Batcher's odd-even merge network one candidate pair per step and
// flags the pairs that form a comparator and lie inside the loaded count.
// ----------------------------------------------------------------------------
`default_nettype none

module oems_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire oems_pkg::seq_ctl_t ctl,
  input  wire oems_pkg::cnt_t     count,
  output oems_pkg::seq_stat_t     stat
);

  localparam int W = oems_pkg::SEQ_W;

  logic [W-1:0] p_r, k_r, j_r, i_r;
  logic [W-1:0] p_nxt, k_nxt, j_nxt, i_nxt;
  logic         done_r, done_nxt;

  logic [W-1:0] cnt_ext, a, b, jk, blk_mask, i_inc, b_inc, p2;
  logic         in_range, same_blk, hit;

  assign cnt_ext  = {1'b0, count};
  assign a        = j_r + i_r;
  assign b        = a + k_r;
  assign jk       = j_r + k_r;
  assign p2       = W'(p_r << 1);
  assign blk_mask = ~(p2 - W'(1));
  assign i_inc    = i_r + W'(1);
  assign b_inc    = b + W'(1);
  assign in_range = jk < cnt_ext;
  // Both ends must fall in the same block of size 2p to form a comparator.
  assign same_blk = ((a ^ b) & blk_mask) == '0;
  assign hit      = !done_r && in_range && (b < cnt_ext) && same_blk;

  assign stat.done = done_r;
  assign stat.hit  = hit;
  assign stat.lo   = a[oems_pkg::IDX_W-1:0];
  assign stat.hi   = b[oems_pkg::IDX_W-1:0];

  always_comb begin
    p_nxt    = p_r;
    k_nxt    = k_r;
    j_nxt    = j_r;
    i_nxt    = i_r;
    done_nxt = done_r;
    if (ctl.start) begin
      p_nxt    = W'(1);
      k_nxt    = W'(1);
      j_nxt    = '0;
      i_nxt    = '0;
      done_nxt = 1'b0;
    end else if (ctl.advance && !done_r) begin
      if (!in_range) begin
        if (k_r == W'(1)) begin
          if (p2 >= cnt_ext) begin
            done_nxt = 1'b1;
          end else begin
            p_nxt = p2;
            k_nxt = p2;
            j_nxt = '0;
            i_nxt = '0;
          end
        end else begin
          k_nxt = k_r >> 1;
          j_nxt = k_r >> 1;
          i_nxt = '0;
        end
      end else if ((i_inc < k_r) && (b_inc < cnt_ext)) begin
        i_nxt = i_inc;
      end else begin
        i_nxt = '0;
        j_nxt = j_r + W'(k_r << 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_r    <= '0;
      k_r    <= '0;
      j_r    <= '0;
      i_r    <= '0;
      done_r <= 1'b1;
    end else begin
      p_r    <= p_nxt;
      k_r    <= k_nxt;
      j_r    <= j_nxt;
      i_r    <= i_nxt;
      done_r <= done_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/oems_chk.sv
// ----------------------------------------------------------------------------
// oems_chk: port-level checks for the odd-even merge sorter
// Watches the stream ports only; attached to the top level by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module oems_chk (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_tvalid,
  input wire logic               in_tready,
  input wire logic               in_tlast,
  input wire logic               out_tvalid,
  input wire logic               out_tready,
  input wire logic signed [31:0] out_tdata,
  input wire logic               out_tlast,
  input wire logic               out_tuser
);

  // The block either loads or emits, never both at once.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input ready while a result is offered");

  // A stalled result stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("result changed under stall");

  // The last input closes loading; the check covers only the drop of in_tready.
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("still loading after the last request");

  // Taking the final result reopens the input side and withdraws the output.
  a_reopen: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tlast |=> in_tready && !out_tvalid)
    else $error("not ready for a new set after the final result");

endmodule

bind odd_even_merge_sort_network_core oems_chk u_oems_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

`default_nettype wire
